// ===== sv/lewg_pkg.sv =====
// Package for the LED effect waveform generator.
// Holds widths, mode and register codes, sequencer states, the quarter-wave
// sine table and the structs passed between the divider, mapper and top.
package lewg_pkg;

  // Field widths
  localparam int LEVEL_W   = 10;
  localparam int MODE_W    = 3;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Q16 shape values run 0..65536, so they need one bit more than Q16
  localparam int SHAPE_W = 17;
  localparam logic [SHAPE_W-1:0] Q_ONE  = 17'h10000;
  localparam logic [SHAPE_W-1:0] Q_HALF = 17'h08000;

  // Divider: numerator is a << 16 with a < den, den up to 17 * period
  localparam int DIV_W  = PERIOD_W + 5;
  localparam int QUO_W  = 16;
  localparam int STEP_W = $clog2(QUO_W);

  // Mapping product: level difference times shape
  localparam int PROD_W = LEVEL_W + SHAPE_W;

  // Quarter-wave sine table, entries 0..SINE_DEPTH-1; the entry at
  // SINE_DEPTH itself is full scale and handled outside the table
  localparam int SINE_DEPTH = 256;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int SINE_SHIFT = 16 - SINE_AW;

  localparam longint unsigned POLY_A = 102944;
  localparam longint unsigned POLY_B = 42334;
  localparam longint unsigned POLY_C = 4926;

  typedef logic [SHAPE_W-1:0] sine_tab_t [SINE_DEPTH];

  typedef enum logic [MODE_W-1:0] {
    MODE_STATIC  = 3'd0,
    MODE_BLINK   = 3'd1,
    MODE_BREATHE = 3'd2,
    MODE_FLASH   = 3'd3,
    MODE_WAVE    = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EFFECT_MODE  = 3'd0,
    REG_PERIOD_MS    = 3'd1,
    REG_LEVEL_LOW    = 3'd2,
    REG_LEVEL_HIGH   = 3'd3,
    REG_STATIC_LEVEL = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SETUP,
    ST_DIV,
    ST_SHAPE,
    ST_MUL,
    ST_DONE
  } state_t;

  // Divider request
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  // Mapper register enables
  typedef struct packed {
    logic shape_en;
    logic prod_en;
  } map_ctl_t;

  // Polynomial sine over a quarter wave, evaluated at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned r;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x  = (longint'(i) * 65536) / SINE_DEPTH;
      x2 = (x * x) >> 16;
      t  = POLY_B - ((x2 * POLY_C) >> 16);
      t  = POLY_A - ((x2 * t) >> 16);
      r  = (x * t) >> 16;
      if (r > 65536) begin
        r = 65536;
      end
      tab[i] = SHAPE_W'(r);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Table lookup for a Q16 angle in 0..65536
  function automatic logic [SHAPE_W-1:0] qsin(input logic [SHAPE_W-1:0] u);
    logic [SINE_AW:0] idx;
    idx = u[SHAPE_W-1:SINE_SHIFT];
    if (idx[SINE_AW]) begin
      return Q_ONE;
    end
    return SINE_TAB[idx[SINE_AW-1:0]];
  endfunction

endpackage

// ===== sv/lewg_in_if.sv =====
// Tick input channel: valid/ready handshake with the restart flag.
// Depends on nothing beyond the language.
interface lewg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== sv/lewg_out_if.sv =====
// Result channel: valid/ready handshake with the level and wrap flag.
// Depends on lewg_pkg for the level width.
interface lewg_out_if import lewg_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               period_wrap;

  modport source (output valid, output level, output period_wrap, input ready);
  modport sink   (input valid, input level, input period_wrap, output ready);
endinterface

// ===== sv/lewg_div.sv =====
// Iterative restoring divider: one compare-and-subtract per cycle.
// Gives floor((num << 16) / den) for num < den. Depends on lewg_pkg.
module lewg_div import lewg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic [QUO_W-1:0] quo,
  output logic             done
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  den_r;
  logic [QUO_W-1:0]  quo_r;

  logic [DIV_W:0]    shifted;
  logic [DIV_W+1:0]  diff;
  logic              ge;
  logic [DIV_W-1:0]  rem_nxt;

  // Shared subtract/compare step
  always_comb begin
    shifted = {rem_r, 1'b0};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    ge      = !diff[DIV_W+1];
    rem_nxt = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
  end

  // Control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && step_r == STEP_W'(QUO_W - 1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      den_r  <= req.den;
      quo_r  <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[QUO_W-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ===== sv/lewg_map.sv =====
// Shape evaluation and level mapping for one tick.
// Sine lookup, shape register, level-difference product. Depends on lewg_pkg.
module lewg_map import lewg_pkg::*; (
  input  logic                clk,
  input  map_ctl_t            ctl,
  input  logic [MODE_W-1:0]   mode,
  input  logic [PERIOD_W-1:0] cnt,
  input  logic [PERIOD_W-1:0] per,
  input  logic                breathe_fall,
  input  logic [QUO_W-1:0]    quo,
  input  logic [LEVEL_W-1:0]  level_low,
  input  logic [LEVEL_W-1:0]  level_high,
  input  logic [LEVEL_W-1:0]  static_level,
  output logic [LEVEL_W-1:0]  level
);

  logic [SHAPE_W-1:0] shape_r;
  logic [PROD_W-1:0]  prod_r;

  logic [SHAPE_W-1:0] sine_arg;
  logic [SHAPE_W-1:0] sine_val;
  logic [SHAPE_W-1:0] shape;
  logic [QUO_W-1:0]   wave_u;
  logic [QUO_W-1:0]   half;
  logic               use_static;
  logic               rising;
  logic [LEVEL_W-1:0] span;
  logic [PROD_W-1:0]  rounded;
  logic [LEVEL_W-1:0] step;

  // Sine angle: wave folds the quadrant, breathe uses the quotient
  always_comb begin
    wave_u = {quo[QUO_W-3:0], 2'b00};
    if (mode_t'(mode) == MODE_WAVE) begin
      sine_arg = quo[QUO_W-2] ? (Q_ONE - {1'b0, wave_u}) : {1'b0, wave_u};
    end else begin
      sine_arg = {1'b0, quo};
    end
    sine_val = qsin(sine_arg);
    half     = sine_val[SHAPE_W-1:1];
  end

  // Shape by mode
  always_comb begin
    use_static = 1'b0;
    case (mode_t'(mode))
      MODE_BLINK: begin
        shape = ({cnt, 1'b0} < {1'b0, per}) ? '0 : Q_ONE;
      end
      MODE_BREATHE: begin
        shape = breathe_fall ? (Q_ONE - sine_val) : sine_val;
      end
      MODE_FLASH: begin
        shape = Q_ONE - {1'b0, quo};
      end
      MODE_WAVE: begin
        shape = quo[QUO_W-1] ? (Q_HALF - {1'b0, half}) : (Q_HALF + {1'b0, half});
      end
      default: begin
        shape      = '0;
        use_static = 1'b1;
      end
    endcase
  end

  // Level span, rising or falling
  always_comb begin
    rising = level_high >= level_low;
    span   = rising ? (level_high - level_low) : (level_low - level_high);
  end

  always_ff @(posedge clk) begin
    if (ctl.shape_en) begin
      shape_r <= shape;
    end
    if (ctl.prod_en) begin
      prod_r <= PROD_W'(span) * PROD_W'(shape_r);
    end
  end

  // Round to nearest and offset from the low level; static mode gives the static level
  always_comb begin
    rounded = prod_r + PROD_W'(Q_HALF);
    step    = rounded[LEVEL_W+15:16];
    if (use_static) begin
      level = static_level;
    end else if (rising) begin
      level = level_low + step;
    end else begin
      level = level_low - step;
    end
  end

endmodule

// ===== sv/led_effect_waveform_generator_core.sv =====
// LED effect waveform generator, top level.
// Usage:
//   in_ch  (sink)   one word per millisecond tick; restart clears the elapsed
//                   count before the tick is evaluated.
//   out_ch (source) one word per tick: 10-bit level and period_wrap.
//   cfg_*           write port; registers are effect_mode, period_ms,
//                   level_low, level_high, static_level (index 0..4).
//                   Write only while no tick is in flight.
// Sequence: a tick in static or blink mode passes COUNT, SETUP, SHAPE, MUL
//   and DONE; breathe, flash and wave add a 16-step divide before SHAPE.
//   in_ch.ready returns as the result is loaded into the output register,
//   so a new tick is taken only once the sequencer is back in idle.
// Reset: synchronous, active low; registers go to mode static, period 1000,
//   range 0..1023, static level 1023, elapsed count 0.
// Stall: the output register holds a finished word while out_ch.ready is
//   low; one more tick may be taken and worked up to the output stage, where
//   it waits for the register to free.
// Depends on lewg_pkg, lewg_in_if, lewg_out_if, lewg_div and lewg_map.
module led_effect_waveform_generator_core import lewg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lewg_in_if.sink              in_ch,
  lewg_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // Configuration registers
  logic [MODE_W-1:0]   effect_mode_r;
  logic [PERIOD_W-1:0] period_ms_r;
  logic [LEVEL_W-1:0]  level_low_r;
  logic [LEVEL_W-1:0]  level_high_r;
  logic [LEVEL_W-1:0]  static_level_r;

  // Sequencer and tick state
  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] elapsed_count_r;
  logic                restart_r;
  logic [PERIOD_W-1:0] cnt_r;
  logic                wrap_r;
  logic                fall_r;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  out_level_r;
  logic                out_wrap_r;

  logic                in_acc;
  logic                out_load;
  logic [PERIOD_W-1:0] per_eff;
  logic [PERIOD_W-1:0] cnt_pre;
  logic [PERIOD_W-1:0] cnt_cur;
  logic [PERIOD_W:0]   cnt_inc;
  logic                wrap_now;
  logic [DIV_W-1:0]    t20;
  logic [DIV_W-1:0]    p3;
  logic [DIV_W-1:0]    p17;
  logic                fall_now;
  logic                need_div;
  div_req_t            div_req;
  logic [QUO_W-1:0]    quo;
  logic                div_done;
  map_ctl_t            map_ctl;
  logic [LEVEL_W-1:0]  level;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_mode_r  <= MODE_STATIC;
      period_ms_r    <= 16'd1000;
      level_low_r    <= '0;
      level_high_r   <= '1;
      static_level_r <= '1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EFFECT_MODE:  effect_mode_r  <= cfg_data[MODE_W-1:0];
        REG_PERIOD_MS:    period_ms_r    <= cfg_data[PERIOD_W-1:0];
        REG_LEVEL_LOW:    level_low_r    <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_HIGH:   level_high_r   <= cfg_data[LEVEL_W-1:0];
        REG_STATIC_LEVEL: static_level_r <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Count handling: zero period acts as one
  always_comb begin
    per_eff  = (period_ms_r == '0) ? PERIOD_W'(1) : period_ms_r;
    cnt_pre  = restart_r ? '0 : elapsed_count_r;
    cnt_cur  = (cnt_pre >= per_eff) ? '0 : cnt_pre;
    cnt_inc  = {1'b0, cnt_cur} + 1'b1;
    wrap_now = cnt_inc >= {1'b0, per_eff};
  end

  // Divider operands from the evaluated count
  always_comb begin
    t20      = {1'b0, cnt_r, 4'b0000} + {3'b000, cnt_r, 2'b00};
    p3       = {4'b0000, per_eff, 1'b0} + {5'b00000, per_eff};
    p17      = {1'b0, per_eff, 4'b0000} + {5'b00000, per_eff};
    fall_now = t20 >= p3;
    need_div = 1'b0;
    case (mode_t'(effect_mode_r)) inside
      MODE_BREATHE, MODE_FLASH, MODE_WAVE: need_div = 1'b1;
      default: need_div = 1'b0;
    endcase
    div_req.start = (state_r == ST_SETUP) && need_div;
    if (mode_t'(effect_mode_r) == MODE_BREATHE) begin
      div_req.num = fall_now ? (t20 - p3) : t20;
      div_req.den = fall_now ? p17 : p3;
    end else begin
      div_req.num = {5'b00000, cnt_r};
      div_req.den = {5'b00000, per_eff};
    end
  end

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    in_acc           = 1'b0;
    out_load         = 1'b0;
    map_ctl.shape_en = 1'b0;
    map_ctl.prod_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_acc = in_ch.valid;
        if (in_ch.valid) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = need_div ? ST_DIV : ST_SHAPE;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        map_ctl.shape_en = 1'b1;
        state_nxt        = ST_MUL;
      end
      ST_MUL: begin
        map_ctl.prod_en = 1'b1;
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_count_r <= '0;
    end else if (state_r == ST_COUNT) begin
      elapsed_count_r <= wrap_now ? '0 : cnt_inc[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      restart_r <= in_ch.restart;
    end
    if (state_r == ST_COUNT) begin
      cnt_r  <= cnt_cur;
      wrap_r <= wrap_now;
    end
    if (state_r == ST_SETUP) begin
      fall_r <= fall_now;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level_r <= level;
      out_wrap_r  <= wrap_r;
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.level       = out_level_r;
  assign out_ch.period_wrap = out_wrap_r;

  lewg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .quo   (quo),
    .done  (div_done)
  );

  lewg_map u_map (
    .clk          (clk),
    .ctl          (map_ctl),
    .mode         (effect_mode_r),
    .cnt          (cnt_r),
    .per          (per_eff),
    .breathe_fall (fall_r),
    .quo          (quo),
    .level_low    (level_low_r),
    .level_high   (level_high_r),
    .static_level (static_level_r),
    .level        (level)
  );

  // The divider only reports completion while the sequencer waits for it
  ap_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider done outside divide state");

  // The evaluated count is always below the effective period
  ap_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETUP) |-> cnt_r < per_eff)
    else $error("evaluated count not below period");

  // A wrap leaves the elapsed count at zero
  ap_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETUP && wrap_r) |-> elapsed_count_r == '0)
    else $error("wrap without cleared count");

  // Finishing a tick always presents a word
  ap_done_presents: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("finished tick not presented");

endmodule
